/* hdl/tty_ild_pkg.sv */
// Package for the tty input line discipline: sizes, character codes, register indexes, FSM states.
`timescale 1ns / 1ps
`default_nettype none

package tty_ild_pkg;

   // Line store geometry
   localparam int LINE_LEN  = 32;
   localparam int ADDR_W    = $clog2(LINE_LEN);
   localparam int CNT_W     = $clog2(LINE_LEN + 1);
   localparam int CSR_IDX_W = 3;

   // Character codes
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] CTRL_FLIP  = 8'h40;

   // input_flags bits
   localparam int IF_IGNCR = 0;
   localparam int IF_ICRNL = 1;
   localparam int IF_INLCR = 2;

   // local_flags bits
   localparam int LF_ECHO  = 0;
   localparam int LF_CARET = 1;
   localparam int LF_CANON = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_FLAGS = 3'd0,
      CSR_LOCAL_FLAGS = 3'd1,
      CSR_ERASE_CHAR  = 3'd2,
      CSR_EOF_CHAR    = 3'd3,
      CSR_EOL_CHAR    = 3'd4,
      CSR_EOL2_CHAR   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ECHO,
      ST_RAW,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

/* hdl/tty_input_line_discipline.sv */
// Top level of the tty input line discipline: mapping, echo, line store and delivery.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  req     | in        | req_valid/req_ready | req_rx_byte[7:0]
//  rsp     | out       | rsp_valid/rsp_ready | rsp_target, rsp_data[7:0], rsp_wake, rsp_last
//  csr     | in        | csr_valid/csr_ready | csr_index[2:0], csr_data[7:0]
//
// A byte transaction is taken in the idle state, mapped and classified in that cycle and,
// in canonical mode, written to the line store there. Echo bytes then leave at one per
// cycle while rsp is not stalled (up to three), then a raw byte. A flush reads the store
// through its registered read port. A byte with no result leaves req_ready high. Reset is
// synchronous, sets the configuration registers to defaults and clears the FSM, line count
// and rsp_valid; the store has no reset. A stalled rsp holds its result and the FSM waits.
`timescale 1ns / 1ps
`default_nettype none

module tty_input_line_discipline
   import tty_ild_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // receive byte channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_rx_byte,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_target,
   output logic [7:0]                rsp_data,
   output logic                      rsp_wake,
   output logic                      rsp_last,
   // register write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_data
);

   // ---------------- configuration registers ----------------
   logic [2:0] input_flags_ff;
   logic [2:0] local_flags_ff;
   logic [7:0] erase_char_ff;
   logic [7:0] eof_char_ff;
   logic [7:0] eol_char_ff;
   logic [7:0] eol2_char_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_flags_ff <= 3'd2;
         local_flags_ff <= 3'd7;
         erase_char_ff  <= 8'h08;
         eof_char_ff    <= 8'h04;
         eol_char_ff    <= 8'h00;
         eol2_char_ff   <= 8'h00;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_INPUT_FLAGS: input_flags_ff <= csr_data[2:0];
            CSR_LOCAL_FLAGS: local_flags_ff <= csr_data[2:0];
            CSR_ERASE_CHAR:  erase_char_ff  <= csr_data;
            CSR_EOF_CHAR:    eof_char_ff    <= csr_data;
            CSR_EOL_CHAR:    eol_char_ff    <= csr_data;
            CSR_EOL2_CHAR:   eol2_char_ff   <= csr_data;
            default: ; // unknown index: write dropped
         endcase
      end
   end

   // ---------------- state ----------------
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;      // bytes held in the line
   logic [7:0]         ech_ff [3];               // pending echo bytes
   logic [7:0]         ech_in [3];
   logic [1:0]         ech_len_ff, ech_len_in;
   logic [1:0]         ech_idx_ff, ech_idx_in;
   logic               raw_ff, raw_in;           // reader byte follows echo
   logic               flush_ff, flush_in;       // line delivery follows echo
   logic [7:0]         byte_ff, byte_in;         // mapped byte for raw delivery
   logic [ADDR_W-1:0]  flast_ff, flast_in;       // index of last byte in flushed line
   logic [ADDR_W-1:0]  idx_ff, idx_in;           // flush read pointer
   logic               q_ok_ff, q_ok_in;         // mem_q_ff holds entry idx_ff

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_target_ff, rsp_target_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_wake_ff, rsp_wake_in;
   logic               rsp_last_ff, rsp_last_in;

   // line store: one write port (accept cycle), one registered read port (flush)
   logic [7:0]         line_mem [LINE_LEN];
   logic [7:0]         mem_q_ff;
   logic               mem_we;

   // ---------------- byte classification ----------------
   logic [7:0] c_map;
   logic       drop_cr;
   logic       echo_on, caret_on, canon_on;
   logic       is_erase, is_end, is_ctl;
   logic       slot_free, ech_at_end;

   assign echo_on  = local_flags_ff[LF_ECHO];
   assign caret_on = local_flags_ff[LF_CARET];
   assign canon_on = local_flags_ff[LF_CANON];

   assign drop_cr = (req_rx_byte == CHAR_CR) && input_flags_ff[IF_IGNCR];

   always_comb begin
      if (req_rx_byte == CHAR_CR && input_flags_ff[IF_ICRNL])
         c_map = CHAR_NL;
      else if (req_rx_byte == CHAR_NL && input_flags_ff[IF_INLCR])
         c_map = CHAR_CR;
      else
         c_map = req_rx_byte;
   end

   assign is_erase = canon_on && (c_map == erase_char_ff);
   assign is_end   = (c_map == eof_char_ff) || (c_map == CHAR_NL) ||
                     (c_map == eol_char_ff) || (c_map == eol2_char_ff);
   // TAB and NL echo as themselves even with caret echo on
   assign is_ctl   = ((c_map < CHAR_SPACE) || (c_map == CHAR_DEL)) &&
                     (c_map != CHAR_TAB) && (c_map != CHAR_NL);

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign ech_at_end = (ech_idx_ff == ech_len_ff - 2'd1);

   // ---------------- next state ----------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ech_in        = ech_ff;
      ech_len_in    = ech_len_ff;
      ech_idx_in    = ech_idx_ff;
      raw_in        = raw_ff;
      flush_in      = flush_ff;
      byte_in       = byte_ff;
      flast_in      = flast_ff;
      idx_in        = idx_ff;
      mem_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_target_in = rsp_target_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_wake_in   = rsp_wake_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ech_idx_in = 2'd0;
               ech_len_in = 2'd0;
               idx_in     = '0;
               raw_in     = 1'b0;
               flush_in   = 1'b0;
               byte_in    = c_map;
               if (!drop_cr) begin
                  if (is_erase) begin
                     // erase on empty line does nothing
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                        if (echo_on) begin
                           ech_in[0]  = CHAR_BS;
                           ech_in[1]  = CHAR_SPACE;
                           ech_in[2]  = CHAR_BS;
                           ech_len_in = 2'd3;
                        end
                     end
                  end else begin
                     if (echo_on) begin
                        if (caret_on && is_ctl) begin
                           ech_in[0]  = CHAR_CARET;
                           ech_in[1]  = c_map ^ CTRL_FLIP;
                           ech_len_in = 2'd2;
                        end else begin
                           ech_in[0]  = c_map;
                           ech_len_in = 2'd1;
                        end
                     end
                     if (canon_on) begin
                        mem_we   = 1'b1;
                        flast_in = count_ff[ADDR_W-1:0];
                        if (is_end || count_ff == CNT_W'(LINE_LEN - 1)) begin
                           flush_in = 1'b1;
                           count_in = '0;
                        end else begin
                           count_in = count_ff + CNT_W'(1);
                        end
                     end else begin
                        raw_in = 1'b1;
                     end
                  end
               end
               if (ech_len_in != 2'd0)
                  state_in = ST_ECHO;
               else if (raw_in)
                  state_in = ST_RAW;
               else if (flush_in)
                  state_in = ST_FLUSH;
               else
                  state_in = ST_IDLE;
            end
         end

         ST_ECHO: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_target_in = 1'b0;
               rsp_data_in   = ech_ff[ech_idx_ff];
               rsp_wake_in   = 1'b0;
               rsp_last_in   = ech_at_end && !raw_ff && !flush_ff;
               if (ech_at_end) begin
                  if (raw_ff)
                     state_in = ST_RAW;
                  else if (flush_ff)
                     state_in = ST_FLUSH;
                  else
                     state_in = ST_IDLE;
               end else begin
                  ech_idx_in = ech_idx_ff + 2'd1;
               end
            end
         end

         ST_RAW: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_target_in = 1'b1;
               rsp_data_in   = byte_ff;
               rsp_wake_in   = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_FLUSH: begin
            if (slot_free && q_ok_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_target_in = 1'b1;
               rsp_data_in   = mem_q_ff;
               rsp_wake_in   = (idx_ff == flast_ff);
               rsp_last_in   = (idx_ff == flast_ff);
               if (idx_ff == flast_ff)
                  state_in = ST_IDLE;
               else
                  idx_in = idx_ff + ADDR_W'(1);
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // read data is good once the pointer has held still while in flush
      q_ok_in = (state_ff == ST_FLUSH) && (state_in == ST_FLUSH) && (idx_in == idx_ff);
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         q_ok_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         q_ok_ff      <= q_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ech_ff        <= ech_in;
      ech_len_ff    <= ech_len_in;
      ech_idx_ff    <= ech_idx_in;
      raw_ff        <= raw_in;
      flush_ff      <= flush_in;
      byte_ff       <= byte_in;
      flast_ff      <= flast_in;
      idx_ff        <= idx_in;
      rsp_target_ff <= rsp_target_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_wake_ff   <= rsp_wake_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // line store write (accept cycle only) and registered read
   always_ff @(posedge clock) begin
      if (mem_we)
         line_mem[count_ff[ADDR_W-1:0]] <= c_map;
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= line_mem[idx_ff];
   end

   // ---------------- ports ----------------
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_target = rsp_target_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_wake   = rsp_wake_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

/* hdl/tty_ild_checker.sv */
// Port-level checker for the tty input line discipline, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tty_ild_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic [7:0]           req_rx_byte,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_target,
   input wire logic [7:0]           rsp_data,
   input wire logic                 rsp_wake,
   input wire logic                 rsp_last
);

   // offered byte holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_rx_byte))
      else $error("req transaction changed while waiting");

   // result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_target)
         && $stable(rsp_last) && $stable(rsp_wake))
      else $error("rsp transaction changed while stalled");

   // a new byte is not taken while the current one still has results to come
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("req_ready high in the middle of a result burst");

   // wake only on the final reader byte
   a_wake_reader_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake |-> rsp_target && rsp_last)
      else $error("wake on an echo or non-final result");

   // nothing pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind tty_input_line_discipline tty_ild_checker u_tty_ild_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_rx_byte (req_rx_byte),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_target  (rsp_target),
   .rsp_data    (rsp_data),
   .rsp_wake    (rsp_wake),
   .rsp_last    (rsp_last)
);

`default_nettype wire

/* tb/tty_input_line_discipline_tb.sv */
// Testbench for tty_input_line_discipline: line discipline scoreboard, byte stimulus and checks.
`timescale 1ns / 1ps

import tty_ild_pkg::*;

// Result destinations
localparam logic TO_ECHO   = 1'b0;
localparam logic TO_READER = 1'b1;

typedef struct packed {
   logic       target;
   logic [7:0] data;
   logic       wake;
   logic       last;
} tty_result_type;

// Scoreboard: tracks the discipline's registers and held line, predicts the
// results of each received byte and checks the block's result stream.
class tty_ild_scoreboard;
   logic [2:0]     iflag;
   logic [2:0]     lflag;
   logic [7:0]     erase_c;
   logic [7:0]     eof_c;
   logic [7:0]     eol_c;
   logic [7:0]     eol2_c;
   logic [7:0]     held_line [LINE_LEN];
   int             held_count;
   tty_result_type step_out[$];
   tty_result_type expected_out[$];
   int             faults;

   function new();
      iflag      = 3'd2;
      lflag      = 3'd7;
      erase_c    = CHAR_BS;
      eof_c      = 8'h04;
      eol_c      = 8'h00;
      eol2_c     = 8'h00;
      held_count = 0;
      faults     = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
         CSR_INPUT_FLAGS: iflag   = val[2:0];
         CSR_LOCAL_FLAGS: lflag   = val[2:0];
         CSR_ERASE_CHAR:  erase_c = val;
         CSR_EOF_CHAR:    eof_c   = val;
         CSR_EOL_CHAR:    eol_c   = val;
         CSR_EOL2_CHAR:   eol2_c  = val;
         default: ;
      endcase
   endfunction

   function void add(logic tgt, logic [7:0] d, logic wk);
      step_out.push_back('{tgt, d, wk, 1'b0});
   endfunction

   // Returns 1 when the byte did anything (results or a change to the held line).
   function bit note_rx_byte(logic [7:0] rx);
      logic [7:0]     c;
      logic           ctl;
      logic           flush;
      tty_result_type r;
      c = rx;
      step_out.delete();
      if (c == CHAR_CR && iflag[IF_IGNCR])
         return 0;
      if (c == CHAR_CR && iflag[IF_ICRNL])
         c = CHAR_NL;
      else if (c == CHAR_NL && iflag[IF_INLCR])
         c = CHAR_CR;

      if (lflag[LF_CANON] && c == erase_c) begin
         if (held_count == 0)
            return 0;
         held_count--;
         if (lflag[LF_ECHO]) begin
            add(TO_ECHO, CHAR_BS, 1'b0);
            add(TO_ECHO, CHAR_SPACE, 1'b0);
            add(TO_ECHO, CHAR_BS, 1'b0);
         end
      end else begin
         if (lflag[LF_ECHO]) begin
            ctl = (c < CHAR_SPACE || c == CHAR_DEL) && c != CHAR_TAB && c != CHAR_NL;
            if (lflag[LF_CARET] && ctl) begin
               add(TO_ECHO, CHAR_CARET, 1'b0);
               add(TO_ECHO, c ^ CTRL_FLIP, 1'b0);
            end else begin
               add(TO_ECHO, c, 1'b0);
            end
         end
         if (lflag[LF_CANON]) begin
            flush = c == eof_c || c == CHAR_NL || c == eol_c || c == eol2_c;
            held_line[held_count] = c;
            held_count++;
            if (held_count >= LINE_LEN)
               flush = 1'b1;
            if (flush) begin
               for (int k = 0; k < held_count; k++)
                  add(TO_READER, held_line[k], k == held_count - 1);
               held_count = 0;
            end
         end else begin
            add(TO_READER, c, 1'b1);
         end
      end

      foreach (step_out[i]) begin
         r = step_out[i];
         r.last = (i == step_out.size() - 1);
         expected_out.push_back(r);
      end
      return 1;
   endfunction

   function void check_result(logic tgt, logic [7:0] d, logic wk, logic lst);
      tty_result_type want;
      if (expected_out.size() == 0) begin
         faults++;
         if (faults <= 10)
            $display("unexpected result: target=%0d data=%02h wake=%0d last=%0d",
                     tgt, d, wk, lst);
         return;
      end
      want = expected_out.pop_front();
      if (want.target !== tgt || want.data !== d || want.wake !== wk || want.last !== lst)
      begin
         faults++;
         if (faults <= 10)
            $display("mismatch: expected target=%0d data=%02h wake=%0d last=%0d, %s",
                     want.target, want.data, want.wake, want.last,
                     $sformatf("got target=%0d data=%02h wake=%0d last=%0d",
                               tgt, d, wk, lst));
      end
   endfunction

   function int pending();
      return expected_out.size();
   endfunction
endclass

module tty_input_line_discipline_tb;

   // Index that decodes to no register; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd6;
   localparam int RANDOM_ITEMS = 150;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_rx_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_target;
   logic [7:0]           rsp_data;
   logic                 rsp_wake;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_data;

   tty_ild_scoreboard sb;
   bit steady;      // phase with no idling on either side
   int rx_taken;    // bytes that did something

   tty_input_line_discipline u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_target  (rsp_target),
      .rsp_data    (rsp_data),
      .rsp_wake    (rsp_wake),
      .rsp_last    (rsp_last),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Special character: usually the customary one, sometimes any byte.
   function automatic logic [7:0] pick_special(logic [7:0] usual);
      if ($urandom_range(0, 2) != 0)
         return usual;
      return 8'($urandom_range(0, 255));
   endfunction

   // One byte transaction on req. Valid drops only ahead of a gap, so
   // back-to-back bytes keep it high with a single assignment per step.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (sb.note_rx_byte(b))
         rx_taken++;
   endtask

   // A typed line: printable text with some erases and stray bytes, then
   // one of the line enders. Now and then it runs past the store size.
   task automatic send_line();
      int         len;
      int         r;
      logic [7:0] enders [5];
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8)
            send_byte(sb.erase_c);
         else if (r < 12)
            send_byte(8'($urandom_range(0, 255)));
         else
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      enders = '{CHAR_NL, CHAR_CR, sb.eof_c, sb.eol_c, sb.eol2_c};
      send_byte(enders[$urandom_range(0, 4)]);
   endtask

   // Stop sending and wait for every expected result. Always waits on
   // a clock edge so valid is never lowered and raised in one step.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   // Full register update while idle. Extra settle cycles cover a byte that
   // produced no result and may still be in flight.
   task automatic set_config(input logic [7:0] inf, input logic [7:0] locf,
                             input logic [7:0] er, input logic [7:0] eo,
                             input logic [7:0] el, input logic [7:0] el2,
                             input bit poke_unused);
      drain();
      repeat (8) @(posedge clock);
      put_reg(CSR_INPUT_FLAGS, inf);
      put_reg(CSR_LOCAL_FLAGS, locf);
      if (poke_unused)
         put_reg(CSR_UNUSED, 8'hFF);
      put_reg(CSR_ERASE_CHAR, er);
      put_reg(CSR_EOF_CHAR, eo);
      put_reg(CSR_EOL_CHAR, el);
      put_reg(CSR_EOL2_CHAR, el2);
      csr_valid <= 1'b0;
   endtask

   // Result side: check each rsp transaction, then pick the next ready level.
   initial begin
      int stall;
      stall = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_target, rsp_data, rsp_wake, rsp_last);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   // Safety net against a hung handshake
   initial begin
      #5_000_000;
      $display("tty_input_line_discipline_tb NOT OK");
      $finish;
   end

   initial begin
      int base;
      int phase;
      int phase_items;
      sb          = new();
      steady      = 1'b0;
      rx_taken    = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_INPUT_FLAGS;
      csr_data    <= 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset settings (CR->NL, echo, caret, canonical) ---
      send_byte(CHAR_BS);     // erase on empty line: nothing
      send_byte(8'h00);       // NUL equals EOL: ^@ and one-byte line
      send_byte(8'h41);
      send_byte(8'hFF);
      send_byte(CHAR_DEL);    // shows as ^?
      send_byte(CHAR_TAB);    // tab echoes as itself
      send_byte(CHAR_BS);     // rubs out the tab
      send_byte(8'h1B);
      send_byte(CHAR_CR);     // mapped to NL, flushes the line
      send_byte(8'h78);
      send_byte(8'h04);       // EOF flush

      // --- directed: all input mappings, flag bits masked, odd specials ---
      set_config(8'h07, 8'hFF, 8'hFF, 8'h00, CHAR_CR, 8'h80, 1'b1);
      send_byte(CHAR_CR);     // ignored
      send_byte(8'h41);
      send_byte(8'hFF);       // erase
      send_byte(CHAR_NL);     // NL->CR, CR is EOL
      send_byte(8'h80);       // EOL2
      send_byte(8'h68);
      send_byte(8'h69);       // "hi" stays held across the raw phase

      // --- directed: raw, silent; then raw with caret echo ---
      set_config(8'h00, 8'h00, CHAR_BS, 8'h04, 8'h00, 8'h00, 1'b0);
      send_byte(CHAR_CR);
      send_byte(8'h00);
      set_config(8'h00, 8'h03, CHAR_BS, 8'h04, 8'h00, 8'h00, 1'b0);
      send_byte(8'h01);
      send_byte(CHAR_DEL);

      // --- directed: canonical, no echo; held line resumes ---
      set_config(8'h02, 8'h04, CHAR_BS, 8'h04, 8'h00, 8'h00, 1'b0);
      send_byte(CHAR_BS);     // silent erase of 'i'
      send_byte(CHAR_NL);     // delivers "h\n"

      // --- random phases ---
      base = rx_taken;
      for (phase = 0; rx_taken < base + RANDOM_ITEMS; phase++) begin
         case (phase)
            0: set_config(8'h07, 8'h07, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
            1: set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
            default:
               set_config(8'($urandom_range(0, 7)),
                          {5'd0, 1'($urandom_range(0, 3) != 0), 2'($urandom_range(0, 3))},
                          pick_special($urandom_range(0, 1) ? CHAR_BS : CHAR_DEL),
                          pick_special(8'h04), pick_special(8'h00),
                          pick_special(8'h00), 1'b0);
         endcase
         steady = (phase % 4 == 3);
         for (phase_items = 0; phase_items < 8 && rx_taken < base + RANDOM_ITEMS;
              phase_items++) begin
            // sender holds off once until the result side is empty
            if (phase == 2 && phase_items == 4)
               drain();
            if ($urandom_range(0, 9) < 7)
               send_line();
            else
               send_byte(8'($urandom_range(0, 255)));
         end
      end

      // wait out the tail, then look for strays
      steady = 1'b0;
      drain();
      repeat (80) @(posedge clock);
      if (sb.faults == 0 && sb.pending() == 0)
         $display("tty_input_line_discipline_tb OK");
      else
         $display("tty_input_line_discipline_tb NOT OK");
      $finish;
   end

endmodule

/* files.f */
hdl/tty_ild_pkg.sv
hdl/tty_input_line_discipline.sv
hdl/tty_ild_checker.sv
tb/tty_input_line_discipline_tb.sv
